// ===== sv/iadec_pkg.sv =====
// ----------------------------------------------------------------------------
// iadec_pkg
// Opcodes, character and BCD codes for the integer ALU to decimal ASCII block.
// ----------------------------------------------------------------------------
package iadec_pkg;

	typedef logic [1:0] opcode_t;
	typedef logic [7:0] char_t;

	localparam opcode_t OP_ADD = 2'd0;
	localparam opcode_t OP_SUB = 2'd1;
	localparam opcode_t OP_MUL = 2'd2;
	localparam opcode_t OP_DIV = 2'd3;

	localparam char_t CHAR_ZERO  = 8'h30;
	localparam char_t CHAR_MINUS = 8'h2D;
	localparam char_t CHAR_NUL   = 8'h00;

	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ     = 4'd3;
	localparam logic [3:0] BCD_MAX     = 4'd9;

endpackage

// ===== sv/int_alu_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// int_alu_to_decimal_ascii_top
// Signed integer ALU with serial decimal ASCII output.
// ----------------------------------------------------------------------------
// Command channel (cmd_valid/cmd_ready) takes opcode, operand_a, operand_b.
// Character channel (char_valid/char_ready) returns one transaction per
// character, most significant first, '-' leading for negatives unless the
// digits fill all MAX_CHARS places, last_char set on the final one.
// Divide by zero returns a single NUL with status 1. Operands are
// sign-extended from 32 bits, then cut to DATA_WIDTH bits.
// Characters go out one per cycle when the receiver takes them.
// Multiply is shift-add and divide is restoring, one bit per cycle; the
// decimal conversion is a double-dabble shifter, one bit per cycle. Both
// loops run over DATA_WIDTH bits.
// One command is in work at a time; cmd_ready is high only when idle.
// The character register decouples the output: when the receiver stalls the
// block holds the current character and waits. The last character may still
// wait in that register while the next command is accepted.
// Reset clears the control state and drops char_valid.
// ----------------------------------------------------------------------------
module int_alu_to_decimal_ascii_top #(
	parameter int DATA_WIDTH = 32,
	parameter int MAX_CHARS  = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [1:0]  opcode,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic        char_valid,
	input  logic        char_ready,
	output logic [7:0]  out_char,
	output logic        last_char,
	output logic        status
);

	localparam int W  = DATA_WIDTH;
	localparam int IW = $clog2(MAX_CHARS);
	localparam int CW = $clog2(MAX_CHARS + 1);
	localparam int NW = $clog2(DATA_WIDTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CALC = 3'd1;
	localparam logic [2:0] ST_FIX  = 3'd2;
	localparam logic [2:0] ST_MAG  = 3'd3;
	localparam logic [2:0] ST_CONV = 3'd4;
	localparam logic [2:0] ST_LEN  = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;
	localparam logic [2:0] ST_ERR  = 3'd7;

	logic [2:0]             state_q;
	iadec_pkg::opcode_t     op_q;
	logic                   qneg_q;
	logic                   neg_q;
	logic [NW-1:0]          cnt_q;
	logic [W-1:0]           acc_q;
	logic [W-1:0]           x_q;
	logic [W-1:0]           y_q;
	logic [W-1:0]           res_q;
	logic [3:0]             bcd_q [MAX_CHARS];
	logic                   ovf_q;
	logic [CW-1:0]          ndig_q;
	logic                   minus_q;
	logic [IW-1:0]          pos_q;

	logic                   char_valid_q;
	iadec_pkg::char_t       out_char_q;
	logic                   last_char_q;
	logic                   status_q;

	logic [63:0]            a_ext;
	logic [63:0]            b_ext;
	logic [W-1:0]           a_w;
	logic [W-1:0]           b_w;
	logic [W-1:0]           a_mag;
	logic [W-1:0]           b_mag;
	logic [W-1:0]           rem_sh;
	logic                   rem_ge;
	logic [W-1:0]           acc_nx;
	logic [W-1:0]           x_nx;
	logic [3:0]             bcd_adj [MAX_CHARS];
	logic [3:0]             bcd_nx [MAX_CHARS];
	logic [CW-1:0]          nd;
	logic                   has_minus;
	logic                   out_free;
	logic                   cmd_fire;
	logic                   emit_ld;
	iadec_pkg::char_t       emit_char;

	assign cmd_ready  = (state_q == ST_IDLE);
	assign cmd_fire   = cmd_valid && cmd_ready;
	assign out_free   = !char_valid_q || char_ready;
	assign char_valid = char_valid_q;
	assign out_char   = out_char_q;
	assign last_char  = last_char_q;
	assign status     = status_q;

	assign a_ext = {{32{operand_a[31]}}, operand_a};
	assign b_ext = {{32{operand_b[31]}}, operand_b};
	assign a_w   = a_ext[W-1:0];
	assign b_w   = b_ext[W-1:0];
	assign a_mag = a_w[W-1] ? (~a_w + W'(1)) : a_w;
	assign b_mag = b_w[W-1] ? (~b_w + W'(1)) : b_w;

	// one shift-add or one restoring-divide step
	assign rem_sh = {acc_q[W-2:0], x_q[W-1]};
	assign rem_ge = (rem_sh >= y_q);

	always_comb begin
		if (op_q == iadec_pkg::OP_MUL) begin
			acc_nx = y_q[0] ? (acc_q + x_q) : acc_q;
			x_nx   = {x_q[W-2:0], 1'b0};
		end else begin
			acc_nx = rem_ge ? (rem_sh - y_q) : rem_sh;
			x_nx   = {x_q[W-2:0], rem_ge};
		end
	end

	// double dabble: add 3 to digits of 5 or more, then shift one bit in
	always_comb begin
		for (int i = 0; i < MAX_CHARS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= iadec_pkg::BCD_ADJ_MIN) ?
				(bcd_q[i] + iadec_pkg::BCD_ADJ) : bcd_q[i];
		end
		bcd_nx[0] = {bcd_adj[0][2:0], x_q[W-1]};
		for (int i = 1; i < MAX_CHARS; i++) begin
			bcd_nx[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
		end
	end

	// text wider than the buffer keeps all MAX_CHARS low digits
	always_comb begin
		nd = '0;
		for (int i = 0; i < MAX_CHARS; i++) begin
			if (bcd_q[i] != 4'd0) begin
				nd = CW'(i + 1);
			end
		end
		if (nd == '0) begin
			nd = CW'(1);
		end
		if (ovf_q) begin
			nd = CW'(MAX_CHARS);
		end
		has_minus = neg_q && (nd != CW'(MAX_CHARS));
	end

	always_comb begin
		if (minus_q && (CW'(pos_q) == ndig_q)) begin
			emit_char = iadec_pkg::CHAR_MINUS;
		end else begin
			emit_char = iadec_pkg::CHAR_ZERO + {4'd0, bcd_q[pos_q]};
		end
	end

	assign emit_ld = (state_q == ST_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (opcode)
							iadec_pkg::OP_ADD, iadec_pkg::OP_SUB: state_q <= ST_MAG;
							iadec_pkg::OP_MUL: state_q <= ST_CALC;
							iadec_pkg::OP_DIV: state_q <= (b_w == '0) ? ST_ERR : ST_CALC;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CALC: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: state_q <= ST_MAG;
				ST_MAG: state_q <= ST_CONV;
				ST_CONV: begin
					if (cnt_q == '0) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free && (pos_q == '0)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					op_q   <= opcode;
					qneg_q <= a_w[W-1] ^ b_w[W-1];
					acc_q  <= '0;
					cnt_q  <= NW'(W - 1);
					case (opcode)
						iadec_pkg::OP_ADD: res_q <= a_w + b_w;
						iadec_pkg::OP_SUB: res_q <= a_w - b_w;
						iadec_pkg::OP_MUL: begin
							x_q <= a_w;
							y_q <= b_w;
						end
						default: begin
							x_q <= a_mag;
							y_q <= b_mag;
						end
					endcase
				end
			end
			ST_CALC: begin
				acc_q <= acc_nx;
				x_q   <= x_nx;
				y_q   <= (op_q == iadec_pkg::OP_MUL) ? {1'b0, y_q[W-1:1]} : y_q;
				cnt_q <= cnt_q - NW'(1);
				if (cnt_q == '0) begin
					res_q <= (op_q == iadec_pkg::OP_MUL) ? acc_nx : x_nx;
				end
			end
			ST_FIX: begin
				if ((op_q == iadec_pkg::OP_DIV) && qneg_q) begin
					res_q <= ~res_q + W'(1);
				end
			end
			ST_MAG: begin
				neg_q <= res_q[W-1];
				x_q   <= res_q[W-1] ? (~res_q + W'(1)) : res_q;
				cnt_q <= NW'(W - 1);
				ovf_q <= 1'b0;
				for (int i = 0; i < MAX_CHARS; i++) begin
					bcd_q[i] <= 4'd0;
				end
			end
			ST_CONV: begin
				bcd_q <= bcd_nx;
				ovf_q <= ovf_q || bcd_adj[MAX_CHARS-1][3];
				x_q   <= {x_q[W-2:0], 1'b0};
				cnt_q <= cnt_q - NW'(1);
			end
			ST_LEN: begin
				ndig_q  <= nd;
				minus_q <= has_minus;
				pos_q   <= has_minus ? IW'(nd) : IW'(nd - CW'(1));
			end
			ST_EMIT: begin
				if (out_free) begin
					pos_q <= pos_q - IW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
		end else if (emit_ld || ((state_q == ST_ERR) && out_free)) begin
			char_valid_q <= 1'b1;
		end else if (char_ready) begin
			char_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ld) begin
			out_char_q  <= emit_char;
			last_char_q <= (pos_q == '0);
			status_q    <= 1'b0;
		end else if ((state_q == ST_ERR) && out_free) begin
			out_char_q  <= iadec_pkg::CHAR_NUL;
			last_char_q <= 1'b1;
			status_q    <= 1'b1;
		end
	end

	a_cmd_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> (state_q != ST_IDLE))
		else $error("command accepted but block stayed idle");

	a_err_char: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && status) |-> (last_char && (out_char == iadec_pkg::CHAR_NUL)))
		else $error("error transaction is not a single NUL");

	a_ok_char: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !status) |->
		(((out_char >= iadec_pkg::CHAR_ZERO) &&
		(out_char <= (iadec_pkg::CHAR_ZERO + 8'd9))) ||
		(out_char == iadec_pkg::CHAR_MINUS)))
		else $error("character is neither a digit nor a minus sign");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (CW'(pos_q) <= ndig_q))
		else $error("emit position beyond the text");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEN) |-> (bcd_q[0] <= iadec_pkg::BCD_MAX))
		else $error("low decimal digit out of range");

endmodule
